// ===== hdl/ismu_pkg.sv =====
// Package for the Ising Metropolis site update block.
// Holds the request and result types, register indexes, sequencer states and shared constants.
// No dependencies.
`default_nettype none
package ismu_pkg;

  localparam int unsigned THR_W     = 17;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_THR   = 4;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned RND_W     = 16;
  localparam int unsigned NB_W      = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THR_DE2 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE4 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE6 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE8 = 4'd3;

  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_UP     = 3'd1;
  localparam logic [2:0] SLOT_DOWN   = 3'd2;
  localparam logic [2:0] SLOT_LEFT   = 3'd3;
  localparam logic [2:0] SLOT_RIGHT  = 3'd4;

  localparam logic [THR_W-1:0] ALU_ONE       = 17'd1;
  localparam logic [THR_W-1:0] ALU_MINUS_ONE = 17'h1FFFF;
  localparam logic [THR_W-1:0] ALU_TWO       = 17'd2;
  localparam logic [THR_W-1:0] ALU_MINUS_TWO = 17'h1FFFE;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             op;
    logic [6:0]       row;
    logic [6:0]       column;
    logic             spin_value;
    logic [RND_W-1:0] random_fraction;
  } ismu_in_t;

  typedef struct packed {
    logic                    flipped;
    logic signed [SUM_W-1:0] magnetization_sum;
  } ismu_out_t;

  typedef struct packed {
    logic [THR_W-1:0] a;
    logic [THR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             borrow;
    logic [THR_W-1:0] diff;
  } alu_rsp_t;

  typedef struct packed {
    logic en;
    logic we;
    logic wdata;
  } ram_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ismu_alu.sv =====
// Shared subtractor of the site update block: difference and borrow of two 17-bit operands.
// Serves neighbor accumulation, threshold compare and spin sum update. Uses ismu_pkg.
`default_nettype none
module ismu_alu
  import ismu_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    rsp_o = {1'b0, req_i.a} - {1'b0, req_i.b};
  end

endmodule
`default_nettype wire

// ===== hdl/ismu_lattice_ram.sv =====
// Single-port spin lattice memory, one bit per site, registered read data.
// Uses ismu_pkg for the port control struct.
`default_nettype none
module ismu_lattice_ram
  import ismu_pkg::*;
#(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  ram_ctl_t      ctl_i,
  input  logic [AW-1:0] addr_i,
  output logic          rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem[addr_i] <= ctl_i.wdata;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/ismu_seq.sv =====
// Sequencer of the site update block: lattice clearing, neighbor reads, accept decision, write-back.
// Drives the shared subtractor and the lattice memory. Uses ismu_pkg.
`default_nettype none
module ismu_seq
  import ismu_pkg::*;
#(
  parameter int unsigned SIDE        = 128,
  parameter int unsigned RANDOM_BITS = 16,
  localparam int unsigned DEPTH      = SIDE * SIDE,
  localparam int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ismu_in_t                      in_data_i,
  input  logic [NUM_THR-1:0][THR_W-1:0] thr_i,
  input  logic                          out_free_i,
  output logic                          done_o,
  output ismu_out_t                     result_o,
  output alu_req_t                      alu_req_o,
  input  alu_rsp_t                      alu_rsp_i,
  output ram_ctl_t                      ram_ctl_o,
  output logic [AW-1:0]                 ram_addr_o,
  input  logic                          ram_rdata_i
);

  localparam logic [AW-1:0] SIDE_A     = AW'(SIDE);
  localparam logic [AW-1:0] ONE_A      = AW'(1);
  localparam logic [AW-1:0] LAST_A     = AW'(DEPTH - 1);
  localparam logic [SUM_W-1:0] TOTAL_RESET = SUM_W'(-(SIDE * SIDE));
  localparam logic [RND_W-1:0] RAND_MASK =
    (RANDOM_BITS >= RND_W) ? {RND_W{1'b1}} : RND_W'((32'd1 << RANDOM_BITS) - 32'd1);

  state_e                state_q, state_d;
  logic [2:0]            step_q, step_d;
  ismu_in_t              req_q, req_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [4:0]            pres_q, pres_d;
  logic                  spin_q, spin_d;
  logic signed [NB_W-1:0] nb_q, nb_d;
  logic                  accept_q, accept_d;
  logic                  flipped_q, flipped_d;
  logic [SUM_W-1:0]      total_q, total_d;
  logic [AW-1:0]         clr_q, clr_d;

  logic                  cap_en;
  logic [2:0]            cap_slot;
  logic                  de_pos;
  logic [NB_W-1:0]       mag;
  logic [1:0]            thr_sel;
  logic                  chg;
  logic                  new_spin;
  logic                  in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      total_q <= TOTAL_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    req_q     <= req_d;
    idx_q     <= idx_d;
    pres_q    <= pres_d;
    spin_q    <= spin_d;
    nb_q      <= nb_d;
    accept_q  <= accept_d;
    flipped_q <= flipped_d;
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    req_d      = req_q;
    idx_d      = idx_q;
    pres_d     = pres_q;
    spin_d     = spin_q;
    nb_d       = nb_q;
    accept_d   = accept_q;
    flipped_d  = flipped_q;
    total_d    = total_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    alu_req_o  = '0;
    ram_ctl_o  = '0;
    ram_addr_o = idx_q;
    cap_en     = 1'b0;
    cap_slot   = SLOT_CENTER;
    chg        = 1'b0;
    new_spin   = 1'b0;

    in_range = (32'(in_data_i.row) < SIDE) && (32'(in_data_i.column) < SIDE);
    de_pos   = spin_q ? (nb_q > 4'sd0) : (nb_q < 4'sd0);
    mag      = spin_q ? nb_q : -nb_q;
    thr_sel  = mag[1:0] - 2'd1;

    case (state_q)
      ST_CLEAR: begin
        ram_ctl_o  = '{en: 1'b1, we: 1'b1, wdata: 1'b0};
        ram_addr_o = clr_q;
        clr_d      = clr_q + ONE_A;
        if (clr_q == LAST_A) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d     = in_data_i;
          idx_d     = AW'(AW'(in_data_i.row) * SIDE_A + AW'(in_data_i.column));
          pres_d[0] = 1'b1;
          pres_d[1] = in_data_i.row != '0;
          pres_d[2] = (32'(in_data_i.row) + 32'd1) < SIDE;
          pres_d[3] = in_data_i.column != '0;
          pres_d[4] = (32'(in_data_i.column) + 32'd1) < SIDE;
          nb_d      = '0;
          step_d    = SLOT_CENTER;
          flipped_d = 1'b0;
          state_d   = in_range ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        ram_ctl_o.en = pres_q[step_q];
        case (step_q)
          SLOT_CENTER: ram_addr_o = idx_q;
          SLOT_UP:     ram_addr_o = idx_q - SIDE_A;
          SLOT_DOWN:   ram_addr_o = idx_q + SIDE_A;
          SLOT_LEFT:   ram_addr_o = idx_q - ONE_A;
          SLOT_RIGHT:  ram_addr_o = idx_q + ONE_A;
          default:     ram_addr_o = idx_q;
        endcase
        cap_en   = step_q != SLOT_CENTER;
        cap_slot = step_q - 3'd1;
        step_d   = step_q + 3'd1;
        if (step_q == SLOT_RIGHT) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cap_en   = 1'b1;
        cap_slot = SLOT_RIGHT;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        alu_req_o.a = {1'b0, req_q.random_fraction & RAND_MASK};
        alu_req_o.b = thr_i[thr_sel];
        accept_d    = !de_pos || alu_rsp_i.borrow;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        if (req_q.op == OP_UPDATE) begin
          chg      = accept_q;
          new_spin = ~spin_q;
        end else begin
          chg      = spin_q != req_q.spin_value;
          new_spin = req_q.spin_value;
        end
        if (chg) begin
          ram_ctl_o   = '{en: 1'b1, we: 1'b1, wdata: new_spin};
          alu_req_o.a = {total_q[SUM_W-1], total_q};
          alu_req_o.b = new_spin ? ALU_MINUS_TWO : ALU_TWO;
          total_d     = alu_rsp_i.diff[SUM_W-1:0];
          flipped_d   = req_q.op == OP_UPDATE;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cap_en) begin
      if (cap_slot == SLOT_CENTER) begin
        spin_d = ram_rdata_i;
      end else if (pres_q[cap_slot]) begin
        alu_req_o.a = {{(THR_W-NB_W){nb_q[NB_W-1]}}, nb_q};
        alu_req_o.b = ram_rdata_i ? ALU_MINUS_ONE : ALU_ONE;
        nb_d        = alu_rsp_i.diff[NB_W-1:0];
      end
    end
  end

  assign result_o.flipped           = flipped_q;
  assign result_o.magnetization_sum = total_q;

endmodule
`default_nettype wire

// ===== hdl/ising_metropolis_site_update.sv =====
// Top level of the Ising Metropolis site update block: threshold registers, result register.
// Instantiates ismu_seq, ismu_alu and ismu_lattice_ram. Uses ismu_pkg.
//
// Metropolis single-site update on a SIDE x SIDE lattice of one-bit spins with open borders.
// After reset the block clears the lattice to all spins down and
// accepts no request meanwhile; threshold writes are taken at any time. A request in the
// lattice steps through the site and four neighbor reads, a last-read step, the threshold compare,
// the write-back and the final step, where its result enters the output register; only then is
// the next request taken. The single-port lattice memory serves one access a cycle, five reads
// (site and four neighbors) and one write-back, and one shared subtractor accumulates neighbors,
// compares the random fraction with the threshold and updates the spin sum. A request outside
// the lattice goes from acceptance straight to the final step. A result that cannot enter the
// output register holds the block in its final step. The next request is accepted while the
// previous result waits in the output register.
`default_nettype none
module ising_metropolis_site_update
  import ismu_pkg::*;
#(
  parameter int unsigned SIDE        = 128,
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ismu_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ismu_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THR_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [THR_W-1:0] THR_RESET =
    (RANDOM_BITS >= THR_W) ? {THR_W{1'b1}} : THR_W'(64'd1 << RANDOM_BITS);

  logic [NUM_THR-1:0][THR_W-1:0] thr_q, thr_d;
  logic                          out_valid_q, out_valid_d;
  ismu_out_t                     out_data_q, out_data_d;

  logic          out_free;
  logic          done;
  ismu_out_t     result;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  ram_ctl_t      ram_ctl;
  logic [AW-1:0] ram_addr;
  logic          ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THR_DE2: thr_d[0] = cfg_data_i;
        REG_THR_DE4: thr_d[1] = cfg_data_i;
        REG_THR_DE6: thr_d[2] = cfg_data_i;
        REG_THR_DE8: thr_d[3] = cfg_data_i;
        default:     thr_d    = thr_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= {NUM_THR{THR_RESET}};
      out_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  ismu_seq #(
    .SIDE        (SIDE),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .thr_i       (thr_q),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .ram_ctl_o   (ram_ctl),
    .ram_addr_o  (ram_addr),
    .ram_rdata_i (ram_rdata)
  );

  ismu_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ismu_lattice_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
